FILE: rtl/hsl2rgb_pkg.sv
// Shared widths, constants and item types for the HSL to RGB converter.
`default_nettype none

package hsl2rgb_pkg;

  localparam int FRAC_BITS = 12;
  localparam int HUE_W     = FRAC_BITS;
  localparam int LVL_W     = FRAC_BITS + 1;
  localparam int H3_W      = FRAC_BITS + 2;
  localparam int OP_W      = LVL_W + 1;
  localparam int PROD_W    = LVL_W + OP_W;
  localparam int RAMP_W    = 2 * LVL_W;

  localparam logic [H3_W-1:0] ONE  = H3_W'(1) << FRAC_BITS;
  localparam logic [H3_W-1:0] HALF = H3_W'(1) << (FRAC_BITS - 1);

  // Segment of the piecewise-linear channel rule
  localparam logic [1:0] SEG_RISE = 2'd0;
  localparam logic [1:0] SEG_HIGH = 2'd1;
  localparam logic [1:0] SEG_FALL = 2'd2;
  localparam logic [1:0] SEG_LOW  = 2'd3;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [LVL_W-1:0] saturation;
    logic [LVL_W-1:0] lightness;
  } hsl_item_t;

  typedef struct packed {
    logic [LVL_W-1:0] red;
    logic [LVL_W-1:0] green;
    logic [LVL_W-1:0] blue;
  } rgb_item_t;

endpackage

`default_nettype wire

FILE: rtl/hsl_to_rgb_converter_core.sv
// Top level of the pipelined HSL to RGB converter.
`default_nettype none

// Converts one hue/saturation/lightness item to red/green/blue per cycle, all
// levels Q1.12 with 4096 meaning 1.0 and results clamped to 0..4096. Four
// register stages: hue scaling and the lightness product, upper/lower levels
// and ramp selection, the three ramp products, then the output register.
// out_valid is raised once an accepted item reaches the output register; throughput
// is one item per cycle while out_stall stays low. Stalls back up stage by
// stage, and empty stages fill even while the output is held.
module hsl_to_rgb_converter_core (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  hsl2rgb_pkg::hsl_item_t  in_data,
  output logic                    out_valid,
  input  wire                     out_stall,
  output hsl2rgb_pkg::rgb_item_t  out_data
);
  import hsl2rgb_pkg::*;

  // stage enables
  logic en1, en2, en3, en4;
  logic v1_r, v2_r, v3_r, v4_r;

  // stage 1 registers
  logic              zs1_r, low1_r;
  logic [LVL_W-1:0]  l1_r, s1_r;
  logic [PROD_W-1:0] p1_r;
  logic [H3_W-1:0]   h1_r [3];

  // stage 2 registers
  logic              zs2_r;
  logic [LVL_W-1:0]  l2_r, lo2_r, hi2_r, d2_r;
  logic [1:0]        seg2_r [3];
  logic [LVL_W-1:0]  m2_r [3];

  // stage 3 registers
  logic              zs3_r;
  logic [LVL_W-1:0]  l3_r, lo3_r, hi3_r;
  logic [1:0]        seg3_r [3];
  logic [RAMP_W-1:0] prod3_r [3];

  rgb_item_t out_r;

  assign en4 = !v4_r || !out_stall;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_stall  = !en1;
  assign out_valid = v4_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // ---------------- stage 1: saturate, scale hue, lightness product
  logic [LVL_W-1:0]  s_c, l_c;
  logic [H3_W-1:0]   h3_c, hr_c;
  logic [H3_W:0]     hb_c;
  logic              low_c;
  logic [OP_W-1:0]   op_c;
  logic [PROD_W-1:0] p_c;

  always_comb begin
    s_c = (H3_W'(in_data.saturation) > ONE) ? LVL_W'(ONE) : in_data.saturation;
    l_c = (H3_W'(in_data.lightness) > ONE) ? LVL_W'(ONE) : in_data.lightness;
    h3_c = H3_W'(in_data.hue) + {1'b0, in_data.hue, 1'b0};
    hr_c = h3_c + ONE;
    if (hr_c >= 3 * ONE) hr_c = hr_c - H3_W'(3 * ONE);
    hb_c = (H3_W + 1)'(h3_c) + (H3_W + 1)'(2 * ONE);
    if (hb_c >= (H3_W + 1)'(3 * ONE)) hb_c = hb_c - (H3_W + 1)'(3 * ONE);
    low_c = H3_W'(l_c) < HALF;
    op_c  = low_c ? OP_W'(ONE) + OP_W'(s_c) : OP_W'(s_c);
    p_c   = PROD_W'(l_c) * PROD_W'(op_c);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      zs1_r   <= (s_c == '0);
      low1_r  <= low_c;
      l1_r    <= l_c;
      s1_r    <= s_c;
      p1_r    <= p_c;
      h1_r[0] <= hr_c;
      h1_r[1] <= h3_c;
      h1_r[2] <= hb_c[H3_W-1:0];
    end
  end

  // ---------------- stage 2: upper and lower levels, ramp segment
  logic [PROD_W-1:0] pr_c;
  logic [H3_W-1:0]   r_c, hi_raw_c, hi_c, l2x_c, lo_c;
  logic [1:0]        seg_c [3];
  logic [LVL_W-1:0]  m_c [3];
  logic [H3_W:0]     h2x_c [3];
  logic [H3_W-1:0]   fall_c [3];

  always_comb begin
    pr_c     = (p1_r + PROD_W'(HALF)) >> FRAC_BITS;
    r_c      = pr_c[H3_W-1:0];
    hi_raw_c = low1_r ? r_c : H3_W'(l1_r) + H3_W'(s1_r) - r_c;
    hi_c     = (hi_raw_c > ONE) ? ONE : hi_raw_c;
    l2x_c    = {1'b0, l1_r};
    l2x_c    = l2x_c << 1;
    lo_c     = (l2x_c > hi_c) ? l2x_c - hi_c : '0;
    if (lo_c > hi_c) lo_c = hi_c;
    for (int c = 0; c < 3; c++) begin
      h2x_c[c]  = {h1_r[c], 1'b0};
      fall_c[c] = H3_W'(2 * ONE) - h1_r[c];
      if (h2x_c[c] < (H3_W + 1)'(ONE)) begin
        seg_c[c] = SEG_RISE;
        m_c[c]   = h2x_c[c][LVL_W-1:0];
      end else if (h2x_c[c] < (H3_W + 1)'(3 * ONE)) begin
        seg_c[c] = SEG_HIGH;
        m_c[c]   = '0;
      end else if (h1_r[c] < 2 * ONE) begin
        seg_c[c] = SEG_FALL;
        m_c[c]   = {fall_c[c][LVL_W-2:0], 1'b0};
      end else begin
        seg_c[c] = SEG_LOW;
        m_c[c]   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      zs2_r <= zs1_r;
      l2_r  <= l1_r;
      lo2_r <= lo_c[LVL_W-1:0];
      hi2_r <= hi_c[LVL_W-1:0];
      d2_r  <= hi_c[LVL_W-1:0] - lo_c[LVL_W-1:0];
      for (int c = 0; c < 3; c++) begin
        seg2_r[c] <= seg_c[c];
        m2_r[c]   <= m_c[c];
      end
    end
  end

  // ---------------- stage 3: ramp products
  always_ff @(posedge clk) begin
    if (en3) begin
      zs3_r <= zs2_r;
      l3_r  <= l2_r;
      lo3_r <= lo2_r;
      hi3_r <= hi2_r;
      for (int c = 0; c < 3; c++) begin
        seg3_r[c]  <= seg2_r[c];
        prod3_r[c] <= RAMP_W'(d2_r) * RAMP_W'(m2_r[c]);
      end
    end
  end

  // ---------------- stage 4: round, add, select, clamp
  logic [RAMP_W-1:0] rr_c [3];
  logic [H3_W-1:0]   v_c [3];
  logic [LVL_W-1:0]  ch_c [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rr_c[c] = (prod3_r[c] + RAMP_W'(HALF)) >> FRAC_BITS;
      case (seg3_r[c])
        SEG_RISE, SEG_FALL: v_c[c] = H3_W'(lo3_r) + rr_c[c][H3_W-1:0];
        SEG_HIGH:           v_c[c] = H3_W'(hi3_r);
        default:            v_c[c] = H3_W'(lo3_r);
      endcase
      if (v_c[c] > ONE) v_c[c] = ONE;
      ch_c[c] = zs3_r ? l3_r : v_c[c][LVL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      out_r.red   <= ch_c[0];
      out_r.green <= ch_c[1];
      out_r.blue  <= ch_c[2];
    end
  end

`ifndef ASSERT_OFF
  a_levels_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (lo2_r <= hi2_r) && (H3_W'(hi2_r) <= ONE))
    else $error("lower level above upper level or upper level above one");

  a_stage3_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !en3 |=> v3_r && $stable(prod3_r[0]) && $stable(lo3_r))
    else $error("stalled item lost in ramp stage");

  a_out_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (H3_W'(out_data.red) <= ONE) && (H3_W'(out_data.green) <= ONE)
                  && (H3_W'(out_data.blue) <= ONE))
    else $error("result channel above one");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the HSL to RGB converter core, with a fixed-point colour predictor.
`default_nettype none

module tb_top;
  import hsl2rgb_pkg::*;

  localparam int              FB         = hsl2rgb_pkg::FRAC_BITS;
  localparam longint unsigned UNIT       = 64'd1 << FB;
  localparam longint unsigned HALF_UNIT  = 64'd1 << (FB - 1);
  localparam int              CYCLE_CAP  = 300000;
  localparam int              DRAIN_WAIT = 12;
  localparam int              PRINT_CAP  = 40;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  hsl_item_t in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  rgb_item_t out_data;

  rgb_item_t expected_rgb[$];
  int        mismatch_count = 0;
  int        pixels_sent = 0;
  int        pixels_checked = 0;
  int        cycle_count = 0;
  int        stall_left = 0;
  bit        no_idle = 1'b0;

  hsl_to_rgb_converter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned clamp_one(longint unsigned v);
    return (v > UNIT) ? UNIT : v;
  endfunction

  // h3 is the channel hue times three, 0..3*UNIT-1
  function automatic longint unsigned ramp_level(longint unsigned h3, longint unsigned lo,
                                                 longint unsigned hi);
    longint unsigned d;
    longint unsigned v;
    d = hi - lo;
    if (2 * h3 < UNIT) begin
      v = lo + ((d * 2 * h3 + HALF_UNIT) >> FB);
    end else if (2 * h3 < 3 * UNIT) begin
      v = hi;
    end else if (h3 < 2 * UNIT) begin
      v = lo + ((d * 2 * (2 * UNIT - h3) + HALF_UNIT) >> FB);
    end else begin
      v = lo;
    end
    return clamp_one(v);
  endfunction

  function automatic rgb_item_t convert_hsl(hsl_item_t px);
    longint unsigned h, s, l, hi, lo, h3, hr, hb;
    rgb_item_t       rgb;
    h = px.hue;
    s = clamp_one(px.saturation);
    l = clamp_one(px.lightness);
    if (s == 0) begin
      rgb.red   = LVL_W'(l);
      rgb.green = LVL_W'(l);
      rgb.blue  = LVL_W'(l);
      return rgb;
    end
    if (l < HALF_UNIT) begin
      hi = (l * (UNIT + s) + HALF_UNIT) >> FB;
    end else begin
      hi = l + s - ((l * s + HALF_UNIT) >> FB);
    end
    hi = clamp_one(hi);
    lo = (2 * l > hi) ? 2 * l - hi : 0;
    if (lo > hi) begin
      lo = hi;
    end
    h3 = 3 * h;
    hr = h3 + UNIT;
    if (hr >= 3 * UNIT) begin
      hr -= 3 * UNIT;
    end
    hb = h3 + 2 * UNIT;
    if (hb >= 3 * UNIT) begin
      hb -= 3 * UNIT;
    end
    rgb.red   = LVL_W'(ramp_level(hr, lo, hi));
    rgb.green = LVL_W'(ramp_level(h3, lo, hi));
    rgb.blue  = LVL_W'(ramp_level(hb, lo, hi));
    return rgb;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    end
  endtask

  always @(posedge clk) begin
    rgb_item_t want;
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_rgb.size());
      $display("== FAIL ==");
      $finish;
    end else if (rst_n && out_valid && !out_stall) begin
      pixels_checked++;
      stall_left = no_idle ? 0 : $urandom_range(0, 4);
      if (expected_rgb.size() == 0) begin
        report_mismatch("unexpected item, red", out_data.red, -1);
      end else begin
        want = expected_rgb.pop_front();
        if (out_data.red !== want.red) report_mismatch("red", out_data.red, want.red);
        if (out_data.green !== want.green) report_mismatch("green", out_data.green, want.green);
        if (out_data.blue !== want.blue) report_mismatch("blue", out_data.blue, want.blue);
      end
    end
  end

  // hold the result channel for the drawn number of cycles after each item
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic send_item(input hsl_item_t px);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = px;
    do @(posedge clk); while (in_stall);
    expected_rgb.push_back(convert_hsl(px));
    pixels_sent++;
  endtask

  function automatic hsl_item_t make_hsl(int h, int s, int l);
    hsl_item_t px;
    px.hue        = HUE_W'(h);
    px.saturation = LVL_W'(s);
    px.lightness  = LVL_W'(l);
    return px;
  endfunction

  function automatic int pick_level();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 13) return $urandom_range(0, 4096);
    if (sel < 15) return $urandom_range(0, 8191);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 1;
      2: return 2047;
      3: return 2048;
      4: return 4095;
      default: return 4096;
    endcase
  endfunction

  function automatic hsl_item_t random_hsl();
    int s;
    s = ($urandom_range(0, 9) == 0) ? 0 : pick_level();
    return make_hsl($urandom_range(0, 4095), s, pick_level());
  endfunction

  task automatic idle_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic test_corners();
    int hues[12] = '{0, 682, 683, 1365, 1366, 2048, 2730, 2731, 3413, 3414, 4095, 341};
    send_item(make_hsl(0, 0, 0));
    send_item(make_hsl(4095, 0, 4096));
    send_item(make_hsl(1234, 0, 8191));      // lightness above one, grey
    send_item(make_hsl(2000, 8191, 2048));   // saturation above one
    send_item(make_hsl(500, 4097, 4097));
    send_item(make_hsl(700, 4096, 0));
    send_item(make_hsl(700, 4096, 4096));
    send_item(make_hsl(100, 4096, 2047));
    send_item(make_hsl(100, 4096, 2048));
    send_item(make_hsl(3000, 4096, 1));      // lower level pinned at zero
    send_item(make_hsl(3000, 1, 4095));
    foreach (hues[i]) send_item(make_hsl(hues[i], 4096, 2048));
    send_item(make_hsl(2731, 2345, 3001));
  endtask

  task automatic test_random_mix(int count);
    repeat (count) begin
      if ($urandom_range(0, 199) == 0) no_idle = ~no_idle;
      send_item(random_hsl());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_back_to_back(int count);
    no_idle = 1'b1;
    repeat (count) send_item(random_hsl());
    no_idle = 1'b0;
  endtask

  // sender waits for the pipeline to empty, then resumes
  task automatic test_drain_pause(int count);
    repeat (count) send_item(random_hsl());
    idle_input();
    wait (expected_rgb.size() == 0);
    repeat (count) send_item(random_hsl());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_corners();
    test_random_mix(900);
    test_back_to_back(200);
    test_drain_pause(20);
    test_random_mix(810);

    idle_input();
    wait (expected_rgb.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("sent %0d pixels (corners, random mix, back-to-back, drain pause),", pixels_sent);
    $display("checked %0d colour results in %0d cycles", pixels_checked, cycle_count);
    if (mismatch_count == 0 && expected_rgb.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
